[rtl/lbd_pkg.sv]
`timescale 1ns / 1ps
package lbd_pkg;

  localparam int ENTRIES = 16;
  localparam int ID_BITS = 32;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int SLOT_W  = 4;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_PROBE  = 1'b1;

  localparam logic KIND_EVICT  = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [ID_BITS-1:0] block_id;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic [ID_BITS-1:0] evicted_id;
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               last;
  } out_t;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  typedef struct packed {
    logic load;
    logic answer_probe;
    logic update_hit;
    logic evict;
    logic insert;
  } cmd_t;

  typedef struct packed {
    logic probe;
    logic hit;
    logic need_evict;
    logic victim_found;
    logic out_free;
  } status_t;

endpackage

[rtl/lbd_ctrl.sv]
`timescale 1ns / 1ps
module lbd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lbd_pkg::status_t status,
  output lbd_pkg::cmd_t    cmd
);
  import lbd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (status.out_free) begin
          if (status.probe) begin
            cmd.answer_probe = 1'b1;
            state_next       = ST_IDLE;
          end else if (status.hit) begin
            cmd.update_hit = 1'b1;
            state_next     = ST_IDLE;
          end else if (status.need_evict && status.victim_found) begin
            cmd.evict = 1'b1;
          end else begin
            cmd.insert = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.answer_probe, cmd.update_hit, cmd.evict, cmd.insert}))
    else $error("more than one command at once");

  assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_BUSY)
    else $error("accepted transaction did not start lookup");

  assert property (@(posedge clk) disable iff (rst)
    cmd.evict |=> state == ST_BUSY)
    else $error("eviction must be followed by further work");

endmodule

[rtl/lbd_dpath.sv]
`timescale 1ns / 1ps
module lbd_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  lbd_pkg::in_t                in_data,
  input  logic                        cfg_valid,
  input  logic [lbd_pkg::CAP_W-1:0]   cfg_data,
  input  lbd_pkg::cmd_t               cmd,
  output lbd_pkg::status_t            status,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lbd_pkg::out_t               out_data
);
  import lbd_pkg::*;

  logic [ID_BITS-1:0] entry_id [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [IDX_W-1:0]   rank [ENTRIES];
  logic [CNT_W-1:0]   count;
  logic [CAP_W-1:0]   capacity;

  logic               op;
  logic [ID_BITS-1:0] id;

  logic               match_found;
  logic [IDX_W-1:0]   match_idx;
  logic               victim_found;
  logic [IDX_W-1:0]   victim_idx;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   ins_slot;
  logic [IDX_W-1:0]   hit_rank;
  logic [IDX_W-1:0]   top_rank;
  logic [CNT_W-1:0]   cap_eff;
  logic               need_evict;
  logic               out_free;
  logic               emit;
  out_t               result;

  always_comb begin
    match_found  = 1'b0;
    match_idx    = '0;
    victim_found = 1'b0;
    victim_idx   = '0;
    free_found   = 1'b0;
    free_idx     = '0;
    top_rank     = IDX_W'(count - CNT_W'(1));
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && entry_id[i] == id) begin
        match_found = 1'b1;
        match_idx   = IDX_W'(i);
      end
      if (valid[i] && rank[i] == top_rank) begin
        victim_found = 1'b1;
        victim_idx   = IDX_W'(i);
      end
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (capacity > CAP_W'(ENTRIES)) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  assign need_evict = (count >= cap_eff) && (count != '0);
  assign ins_slot   = free_found ? free_idx : '0;
  assign hit_rank   = rank[match_idx];
  assign out_free   = !out_valid || out_ready;
  assign emit       = cmd.answer_probe || cmd.update_hit || cmd.evict || cmd.insert;

  assign status.probe        = (op == OP_PROBE);
  assign status.hit          = match_found;
  assign status.need_evict   = need_evict;
  assign status.victim_found = victim_found;
  assign status.out_free     = out_free;

  always_comb begin
    result            = '0;
    result.kind       = KIND_ANSWER;
    result.last       = 1'b1;
    if (cmd.evict) begin
      result.kind       = KIND_EVICT;
      result.last       = 1'b0;
      result.evicted_id = entry_id[victim_idx];
      result.slot       = SLOT_W'(victim_idx);
    end else if (cmd.insert) begin
      result.slot = SLOT_W'(ins_slot);
    end else begin
      result.hit  = match_found;
      result.slot = match_found ? SLOT_W'(match_idx) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_data.operation;
      id <= in_data.block_id;
    end
    if (cmd.insert) begin
      entry_id[ins_slot] <= id;
    end
    if (emit) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(16);
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (cmd.update_hit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == match_idx) begin
          rank[i] <= '0;
        end else if (valid[i] && rank[i] < hit_rank) begin
          rank[i] <= rank[i] + IDX_W'(1);
        end
      end
    end else if (cmd.evict) begin
      valid[victim_idx] <= 1'b0;
      rank[victim_idx]  <= '0;
      count             <= count - CNT_W'(1);
    end else if (cmd.insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == ins_slot) begin
          rank[i] <= '0;
        end else if (valid[i]) begin
          rank[i] <= rank[i] + IDX_W'(1);
        end
      end
      valid[ins_slot] <= 1'b1;
      if (!valid[ins_slot]) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count == CNT_W'($countones(valid)))
    else $error("occupied count disagrees with valid entries");

  assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result overwritten before transaction completed");

  assert property (@(posedge clk) disable iff (rst)
    cmd.evict |=> count == $past(count) - CNT_W'(1))
    else $error("eviction did not decrement count");

  assert property (@(posedge clk) disable iff (rst)
    cmd.insert |=> valid[$past(ins_slot)])
    else $error("inserted entry not valid");

endmodule

[rtl/lru_block_directory_unit.sv]
`timescale 1ns / 1ps
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_data   (lbd_pkg::in_t)
// out      output     out_valid / out_ready  out_data  (lbd_pkg::out_t)
// cfg      input      cfg_valid / cfg_ready  cfg_data  (capacity, 5 bits)
//
// A hit, a probe or a miss without eviction is handled as accept, then
// lookup and answer. Each eviction adds a further busy pass; the parallel compare over
// the 16 entry registers sets the work of each pass.
// Reset (rst, synchronous) clears all entries and sets capacity to 16.
// A held result stalls further work until out_ready takes it.
module lru_block_directory_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  lbd_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lbd_pkg::out_t             out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lbd_pkg::CAP_W-1:0] cfg_data
);
  import lbd_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  lbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lbd_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[sim/tb_lru_block_directory_unit.sv]
`timescale 1ns / 1ps
module tb_lru_block_directory_unit;
  import lbd_pkg::*;

  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int PHASES          = 14;
  localparam int ITEMS_PER_PHASE = 22;
  localparam int POOL_MAX        = 32;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_t              in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data  = '0;

  lru_block_directory_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  logic [ID_BITS-1:0] dir_id    [ENTRIES];
  logic               dir_valid [ENTRIES];
  logic [IDX_W-1:0]   dir_rank  [ENTRIES];
  logic [CNT_W-1:0]   dir_count;
  logic [CAP_W-1:0]   dir_capacity;

  in_t  pending_q  [$];
  out_t expected_q [$];
  out_t want;

  int fail_count     = 0;
  int mismatch_shown = 0;
  int idle_cycles    = 0;
  int in_gap         = 0;
  int out_hold       = 0;
  bit steady         = 1'b0;

  logic [ID_BITS-1:0] id_pool [POOL_MAX];
  int pool_size;
  int cap_plan [PHASES] = '{16, 1, 31, 0, 9, 16, 2, 31, 5, 1, 12, 16, 3, 8};

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ID_BITS-1:0] fresh_id();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  function automatic int effective_capacity();
    int c;
    c = dir_capacity;
    if (c < 1) c = 1;
    if (c > ENTRIES) c = ENTRIES;
    return c;
  endfunction

  // Mirror one lookup in the directory copy and queue the results it causes.
  task automatic predict_lookup(input in_t req);
    int match;
    int victim;
    int free_slot;
    int eff_cap;
    logic [IDX_W-1:0] old_rank;
    out_t res;
    out_t note;
    match = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (match < 0 && dir_valid[i] && dir_id[i] == req.block_id) match = i;
    eff_cap = effective_capacity();
    res = '0;
    res.kind = KIND_ANSWER;
    res.last = 1'b1;
    if (req.operation == OP_PROBE) begin
      res.hit = (match >= 0);
      if (match >= 0) res.slot = SLOT_W'(match);
      expected_q.push_back(res);
    end else if (match >= 0) begin
      old_rank = dir_rank[match];
      for (int i = 0; i < ENTRIES; i++)
        if (dir_valid[i] && dir_rank[i] < old_rank) dir_rank[i] = dir_rank[i] + 1'b1;
      dir_rank[match] = '0;
      res.hit = 1'b1;
      res.slot = SLOT_W'(match);
      expected_q.push_back(res);
    end else begin
      victim = 0;
      while (victim >= 0 && dir_count >= eff_cap && dir_count > 0) begin
        victim = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (victim < 0 && dir_valid[i] && dir_rank[i] == dir_count - 1) victim = i;
        if (victim >= 0) begin
          dir_valid[victim] = 1'b0;
          dir_rank[victim] = '0;
          dir_count = dir_count - 1'b1;
          note = '0;
          note.kind = KIND_EVICT;
          note.evicted_id = dir_id[victim];
          note.slot = SLOT_W'(victim);
          expected_q.push_back(note);
        end
      end
      free_slot = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (free_slot < 0 && !dir_valid[i]) free_slot = i;
      if (free_slot < 0) free_slot = 0;
      for (int i = 0; i < ENTRIES; i++)
        if (dir_valid[i]) dir_rank[i] = dir_rank[i] + 1'b1;
      if (!dir_valid[free_slot]) dir_count = dir_count + 1'b1;
      dir_valid[free_slot] = 1'b1;
      dir_id[free_slot] = req.block_id;
      dir_rank[free_slot] = '0;
      res.hit = 1'b0;
      res.slot = SLOT_W'(free_slot);
      expected_q.push_back(res);
    end
  endtask

  task automatic queue_lookup(input logic op, input logic [ID_BITS-1:0] id);
    in_t req;
    req.operation = op;
    req.block_id = id;
    pending_q.push_back(req);
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    dir_capacity = value;
  endtask

  // Prime the directory with every pool id, then mix hits, misses and probes.
  task automatic run_random_phase(input int cap, input bit no_idle);
    logic op;
    logic [ID_BITS-1:0] id;
    write_capacity(CAP_W'(cap));
    steady = no_idle;
    pool_size = effective_capacity() + $urandom_range(1, 6);
    if (pool_size > POOL_MAX) pool_size = POOL_MAX;
    for (int k = 0; k < pool_size; k++) id_pool[k] = $urandom;
    if ($urandom_range(0, 2) == 0) begin
      id_pool[0] = '0;
      id_pool[1] = '1;
    end
    for (int k = 0; k < pool_size; k++) queue_lookup(OP_ACCESS, id_pool[k]);
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      op = ($urandom_range(0, 3) == 0) ? OP_PROBE : OP_ACCESS;
      if ($urandom_range(0, 4) == 0) id = fresh_id();
      else id = id_pool[$urandom_range(0, pool_size - 1)];
      queue_lookup(op, id);
    end
    wait_quiet();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        dir_id[i] = '0;
        dir_valid[i] = 1'b0;
        dir_rank[i] = '0;
      end
      dir_count = '0;
    end else begin
      if (in_valid && in_ready) predict_lookup(in_data);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          in_data <= pending_q.pop_front();
          in_valid <= 1'b1;
          in_gap = steady ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (mismatch_shown < 10) begin
            mismatch_shown++;
            $display("unexpected result: kind=%0d evicted_id=%h hit=%0d slot=%0d last=%0d",
                     out_data.kind, out_data.evicted_id, out_data.hit, out_data.slot,
                     out_data.last);
          end
        end else begin
          want = expected_q.pop_front();
          if (out_data.kind !== want.kind || out_data.evicted_id !== want.evicted_id ||
              out_data.hit !== want.hit || out_data.slot !== want.slot ||
              out_data.last !== want.last) begin
            fail_count++;
            if (mismatch_shown < 10) begin
              mismatch_shown++;
              $display("mismatch: expected kind=%0d evicted_id=%h hit=%0d slot=%0d last=%0d",
                       want.kind, want.evicted_id, want.hit, want.slot, want.last);
              $display("            actual kind=%0d evicted_id=%h hit=%0d slot=%0d last=%0d",
                       out_data.kind, out_data.evicted_id, out_data.hit, out_data.slot,
                       out_data.last);
            end
          end
        end
      end
      if (out_hold > 0) out_hold--;
      else if (!steady && $urandom_range(0, 2) == 0) out_hold = pick_gap();
      out_ready <= (out_hold == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("** lru_block_directory_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_capacity = CAP_W'(ENTRIES);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    queue_lookup(OP_PROBE, 32'h0000_0000);
    queue_lookup(OP_ACCESS, 32'h0000_0000);
    queue_lookup(OP_ACCESS, 32'hFFFF_FFFF);
    queue_lookup(OP_PROBE, 32'hFFFF_FFFF);
    queue_lookup(OP_ACCESS, 32'h0000_0000);
    queue_lookup(OP_PROBE, 32'h1234_5678);
    queue_lookup(OP_ACCESS, 32'hAAAA_AAAA);
    queue_lookup(OP_ACCESS, 32'h5555_5555);
    wait_quiet();

    // shrink below occupancy: next miss drops several entries in turn
    write_capacity(CAP_W'(2));
    queue_lookup(OP_ACCESS, 32'h0000_0001);
    queue_lookup(OP_PROBE, 32'hFFFF_FFFF);
    queue_lookup(OP_ACCESS, 32'h5555_5555);
    wait_quiet();

    write_capacity(CAP_W'(0));
    queue_lookup(OP_ACCESS, 32'h8000_0000);
    queue_lookup(OP_ACCESS, 32'h7FFF_FFFF);
    queue_lookup(OP_PROBE, 32'h8000_0000);
    wait_quiet();

    write_capacity(CAP_W'(31));
    queue_lookup(OP_ACCESS, 32'hDEAD_BEEF);
    queue_lookup(OP_PROBE, 32'h7FFF_FFFF);
    queue_lookup(OP_ACCESS, 32'h0F0F_F0F0);
    wait_quiet();

    for (int p = 0; p < PHASES; p++) run_random_phase(cap_plan[p], (p % 4) == 3);

    steady = 1'b0;
    wait_quiet();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("** lru_block_directory_unit: PASSED **");
    end else begin
      $display("** lru_block_directory_unit: FAILED **");
    end
    $finish;
  end

endmodule
